/* hw/rtl/isbe_pkg.sv */
package isbe_pkg;

  // POSITIONS must be a multiple of WORD_W.
  localparam int POSITIONS = 65536;
  localparam int WORD_W    = 64;
  localparam int WORDS     = POSITIONS / WORD_W;
  localparam int AW        = $clog2(WORDS);
  localparam int BW        = $clog2(WORD_W);
  localparam int POS_W     = 16;
  localparam int CW        = 21;

  typedef enum logic [2:0] {
    OP_UNION   = 3'd0,
    OP_ISECT   = 3'd1,
    OP_DIFF    = 3'd2,
    OP_RDIFF   = 3'd3,
    OP_SYMDIFF = 3'd4,
    OP_QUERY   = 3'd5
  } op_t;

  typedef logic [WORD_W-1:0] word_t;

endpackage

/* hw/rtl/isbe_ram.sv */
module isbe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/interval_set_bitmap_engine_unit.sv */
// Interval set engine over a bitmap of POSITIONS bits.
// The input channel (in_valid, in_ready) carries one beat per item: op, low_pos
// and high_pos. The output channel (out_valid, out_ready) returns one beat per
// item with member, which is the queried bit for a point query and zero for
// every other op.
// The bitmap lives in one RAM of WORDS words of WORD_W bits. Every range op
// sweeps the whole RAM through one read-modify-write unit, one word a cycle,
// and then passes through a drain state before its result beat is shown.
// A point query reads one word, passing through a read state and the drain
// state; an empty range or an unused op goes straight to its result beat.
// One item is in work at a time: in_ready is low from acceptance until the
// result beat has been taken. If the receiver stalls, the result holds on
// the port and no new item is accepted.
// After reset the block clears the RAM, one word a cycle, with in_ready low.
module interval_set_bitmap_engine_unit
  import isbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       op,
  input  logic [POS_W-1:0] low_pos,
  input  logic [POS_W-1:0] high_pos,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             member
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SWEEP = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_QRD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t           state;
  logic [AW-1:0]    cnt;
  logic [AW-1:0]    wptr;
  logic             pend;
  logic [2:0]       op_r;
  logic [POS_W-1:0] lo_r;
  logic [POS_W-1:0] hi_r;
  logic             qdata;

  logic             we;
  logic [AW-1:0]    waddr;
  word_t            wdata;
  logic [AW-1:0]    raddr;
  word_t            rdata;

  logic [CW-1:0]    lo_w;
  logic [CW-1:0]    hi_w;
  logic [CW-1:0]    cur_w;
  word_t            ge_m;
  word_t            le_m;
  word_t            in_m;
  word_t            upd;

  isbe_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lo_w  = CW'(lo_r >> BW);
  assign hi_w  = CW'(hi_r >> BW);
  assign cur_w = CW'(wptr);

  always_comb begin
    if (lo_w < cur_w) begin
      ge_m = '1;
    end else if (lo_w == cur_w) begin
      ge_m = word_t'('1) << lo_r[BW-1:0];
    end else begin
      ge_m = '0;
    end
    if (hi_w > cur_w) begin
      le_m = '1;
    end else if (hi_w == cur_w) begin
      le_m = word_t'('1) >> (BW'(WORD_W - 1) - hi_r[BW-1:0]);
    end else begin
      le_m = '0;
    end
    in_m = ge_m & le_m;
    case (op_r)
      OP_UNION:   upd = rdata | in_m;
      OP_ISECT:   upd = rdata & in_m;
      OP_DIFF:    upd = rdata & ~in_m;
      OP_RDIFF:   upd = ~rdata & in_m;
      OP_SYMDIFF: upd = rdata ^ in_m;
      default:    upd = rdata;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = wptr;
    wdata = upd;
    raddr = cnt;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = '0;
      end
      ST_SWEEP: we = pend;
      ST_DRAIN: we = pend;
      ST_QRD:   raddr = lo_w[AW-1:0];
      default:  we = 1'b0;
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign member    = qdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      pend  <= 1'b0;
      qdata <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_r  <= op;
            lo_r  <= low_pos;
            hi_r  <= high_pos;
            cnt   <= '0;
            pend  <= 1'b0;
            qdata <= 1'b0;
            if (op == OP_QUERY) begin
              state <= ST_QRD;
            end else if (op <= OP_SYMDIFF && high_pos >= low_pos) begin
              state <= ST_SWEEP;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_SWEEP: begin
          pend <= 1'b1;
          wptr <= cnt;
          cnt  <= cnt + 1'b1;
          if (cnt == AW'(WORDS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pend  <= 1'b0;
          state <= ST_OUT;
        end
        ST_QRD: begin
          state <= ST_DRAIN;
          if (lo_w >= CW'(WORDS)) begin
            pend  <= 1'b0;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
      if (state == ST_DRAIN && op_r == OP_QUERY) begin
        qdata <= rdata[lo_r[BW-1:0]];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready and result shown together");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while busy");

  assert property (@(posedge clk) disable iff (rst)
    (we && op_r == OP_QUERY) |-> (state == ST_CLEAR))
    else $error("query wrote the bitmap");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && op_r != OP_QUERY) |-> !member)
    else $error("non-query result has member set");

endmodule

/* dv/interval_set_bitmap_engine_unit_tb.sv */
module interval_set_bitmap_engine_unit_tb;
  import isbe_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;

  typedef enum int {FILL_CLEAR, FILL_SET, FILL_FLIP} fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] op = OP_QUERY;
  logic [POS_W-1:0] low_pos = '0;
  logic [POS_W-1:0] high_pos = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic member;

  word_t bitmap_mirror [WORDS];
  logic member_q[$];
  bit failed = 1'b0;
  bit gaps_on = 1'b1;
  bit long_hold_req = 1'b0;
  int quiet_cycles = 0;

  interval_set_bitmap_engine_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .low_pos(low_pos), .high_pos(high_pos), .out_valid(out_valid),
    .out_ready(out_ready), .member(member)
  );

  always #1 clk = ~clk;

  function automatic void fill_span(int lo, int hi, fill_t how);
    int wa;
    int wb;
    int a;
    int b;
    word_t mask;
    wa = lo / WORD_W;
    wb = hi / WORD_W;
    for (int w = wa; w <= wb; w++) begin
      a = (w == wa) ? lo % WORD_W : 0;
      b = (w == wb) ? hi % WORD_W : WORD_W - 1;
      mask = ({WORD_W{1'b1}} << a) & ({WORD_W{1'b1}} >> (WORD_W - 1 - b));
      case (how)
        FILL_CLEAR: bitmap_mirror[w] &= ~mask;
        FILL_SET: bitmap_mirror[w] |= mask;
        default: bitmap_mirror[w] ^= mask;
      endcase
    end
  endfunction

  function automatic logic apply_set_op(logic [2:0] code, int lo, int hi);
    if (code == OP_QUERY) begin
      return bitmap_mirror[lo / WORD_W][lo % WORD_W];
    end
    if (hi < lo) begin
      return 1'b0;
    end
    case (code)
      OP_UNION: fill_span(lo, hi, FILL_SET);
      OP_DIFF: fill_span(lo, hi, FILL_CLEAR);
      OP_SYMDIFF: fill_span(lo, hi, FILL_FLIP);
      OP_ISECT, OP_RDIFF: begin
        if (lo > 0) begin
          fill_span(0, lo - 1, FILL_CLEAR);
        end
        if (hi < POSITIONS - 1) begin
          fill_span(hi + 1, POSITIONS - 1, FILL_CLEAR);
        end
        if (code == OP_RDIFF) begin
          fill_span(lo, hi, FILL_FLIP);
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(logic [2:0] code, int lo, int hi);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    low_pos <= lo[POS_W-1:0];
    high_pos <= hi[POS_W-1:0];
    do @(posedge clk); while (!in_ready);
    member_q.push_back(apply_set_op(code, lo, hi));
  endtask

  task automatic send_random_item();
    int r;
    int lo;
    int hi;
    logic [2:0] code;
    r = $urandom_range(0, 99);
    lo = $urandom_range(0, POSITIONS - 1);
    if ($urandom_range(0, 3) == 0) begin
      hi = $urandom_range(0, POSITIONS - 1);
    end else begin
      hi = lo + $urandom_range(0, 2000);
      if (hi > POSITIONS - 1) begin
        hi = POSITIONS - 1;
      end
    end
    if (r < 55) begin
      code = OP_QUERY;
      hi = $urandom_range(0, POSITIONS - 1);
    end else if (r < 57) begin
      code = r[0] ? OP_SPARE6 : OP_SPARE7;
    end else if (r < 60) begin
      code = 3'($urandom_range(0, 4));
      lo = $urandom_range(1, POSITIONS - 1);
      hi = $urandom_range(0, lo - 1);
    end else if (r < 72) begin
      code = OP_UNION;
    end else if (r < 78) begin
      code = OP_ISECT;
      hi = lo + $urandom_range(0, 30000);
      if (hi > POSITIONS - 1) begin
        hi = POSITIONS - 1;
      end
    end else if (r < 86) begin
      code = OP_DIFF;
    end else if (r < 90) begin
      code = OP_RDIFF;
      hi = lo + $urandom_range(0, 30000);
      if (hi > POSITIONS - 1) begin
        hi = POSITIONS - 1;
      end
    end else begin
      code = OP_SYMDIFF;
    end
    send_item(code, lo, hi);
  endtask

  task automatic test_directed();
    send_item(OP_QUERY, 0, 0);
    send_item(OP_UNION, 0, POSITIONS - 1);
    send_item(OP_QUERY, POSITIONS - 1, 0);
    send_item(OP_ISECT, 100, 99);
    send_item(OP_RDIFF, 5000, 4999);
    send_item(OP_QUERY, 7, POSITIONS - 1);
    send_item(OP_ISECT, 10, 200);
    send_item(OP_QUERY, 9, 0);
    send_item(OP_QUERY, 10, 0);
    send_item(OP_QUERY, 200, 0);
    send_item(OP_QUERY, 201, 0);
    send_item(OP_SYMDIFF, 0, POSITIONS - 1);
    send_item(OP_QUERY, 0, 0);
    send_item(OP_QUERY, 100, 0);
    send_item(OP_DIFF, 0, 63);
    send_item(OP_QUERY, 63, 0);
    send_item(OP_RDIFF, 60, 70);
    send_item(OP_QUERY, 60, 0);
    send_item(OP_QUERY, 64, 0);
    send_item(OP_QUERY, 71, 0);
    send_item(OP_SPARE6, 0, POSITIONS - 1);
    send_item(OP_SPARE7, POSITIONS - 1, POSITIONS - 1);
    send_item(OP_UNION, POSITIONS - 1, POSITIONS - 1);
    send_item(OP_QUERY, POSITIONS - 1, POSITIONS - 1);
  endtask

  task automatic test_random(int count);
    repeat (count) send_random_item();
  endtask

  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (6) send_random_item();
  endtask

  task automatic test_drain_pause();
    in_valid <= 1'b0;
    while (member_q.size() != 0) @(posedge clk);
    repeat (10) send_random_item();
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (member_q.size() == 0) begin
        $error("unexpected result beat, member=%0b", member);
        failed = 1'b1;
      end else if (member !== member_q[0]) begin
        $error("member: expected %0b, actual %0b", member_q[0], member);
        failed = 1'b1;
        void'(member_q.pop_front());
      end else begin
        void'(member_q.pop_front());
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("interval_set_bitmap_engine_unit: mismatch");
      $finish;
    end
  end

  initial begin
    for (int w = 0; w < WORDS; w++) begin
      bitmap_mirror[w] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(800);
    test_output_backpressure();
    test_drain_pause();
    test_random(750);
    gaps_on = 1'b0;
    test_random(120);
    in_valid <= 1'b0;
    while (member_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("interval_set_bitmap_engine_unit: match");
    end else begin
      $display("interval_set_bitmap_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/isbe_pkg.sv
hw/rtl/isbe_ram.sv
hw/rtl/interval_set_bitmap_engine_unit.sv
dv/interval_set_bitmap_engine_unit_tb.sv
